### sv/qrm_pkg.sv
package qrm_pkg;

  localparam int NLANE = 9;
  localparam int NW    = 33;

  typedef struct packed {
    logic vld;
    logic zero;
  } ctl_t;

  function automatic logic is_diag(input int k);
    return (k == 0) || (k == 4) || (k == 8);
  endfunction

endpackage

### sv/qrm_front.sv
module qrm_front import qrm_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         vld_i,
  input  logic signed [15:0]           x_i,
  input  logic signed [15:0]           y_i,
  input  logic signed [15:0]           z_i,
  input  logic signed [15:0]           w_i,
  output ctl_t                         ctl_o,
  output logic [NW-1:0]                den_o,
  output logic [NLANE-1:0][NW-1:0]     mag_o,
  output logic [NLANE-1:0]             neg_o
);

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;

  logic                      vld_a_r;
  logic signed [31:0]        xx_r, yy_r, zz_r, ww_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  ctl_t                      ctl_r;
  ctl_t                      ctl_nxt;
  logic [NW-1:0]             den_r, den_nxt;
  logic [NLANE-1:0][NW-1:0]  mag_r, mag_nxt;
  logic [NLANE-1:0]          neg_r, neg_nxt;
  logic [NLANE-1:0][NW:0]    pr;

  function automatic logic [NW:0] pair(input logic signed [31:0] a,
                                       input logic signed [31:0] b,
                                       input logic op);
    logic signed [32:0] s;
    logic [32:0]        m;
    s = (op == OP_SUB) ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
    m = s[32] ? 33'(-s) : 33'(s);
    return {s[32], m[31:0], 1'b0};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r <= x_i * x_i;
      yy_r <= y_i * y_i;
      zz_r <= z_i * z_i;
      ww_r <= w_i * w_i;
      xy_r <= x_i * y_i;
      xz_r <= x_i * z_i;
      yz_r <= y_i * z_i;
      wx_r <= w_i * x_i;
      wy_r <= w_i * y_i;
      wz_r <= w_i * z_i;
    end
  end

  always_comb begin
    pr[0] = pair(yy_r, zz_r, OP_ADD);
    pr[1] = pair(xy_r, wz_r, OP_SUB);
    pr[2] = pair(xz_r, wy_r, OP_ADD);
    pr[3] = pair(xy_r, wz_r, OP_ADD);
    pr[4] = pair(xx_r, zz_r, OP_ADD);
    pr[5] = pair(yz_r, wx_r, OP_SUB);
    pr[6] = pair(xz_r, wy_r, OP_SUB);
    pr[7] = pair(yz_r, wx_r, OP_ADD);
    pr[8] = pair(xx_r, yy_r, OP_ADD);
    for (int k = 0; k < NLANE; k++) begin
      neg_nxt[k] = pr[k][NW];
      mag_nxt[k] = pr[k][NW-1:0];
    end
    den_nxt = NW'($unsigned(xx_r)) + NW'($unsigned(yy_r))
            + NW'($unsigned(zz_r)) + NW'($unsigned(ww_r));
    ctl_nxt.vld  = vld_a_r;
    ctl_nxt.zero = (den_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= den_nxt;
      mag_r <= mag_nxt;
      neg_r <= neg_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign den_o = den_r;
  assign mag_o = mag_r;
  assign neg_o = neg_r;

endmodule

### sv/qrm_div.sv
module qrm_div import qrm_pkg::*; #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  ctl_t                                  ctl_i,
  input  logic [NW-1:0]                         den_i,
  input  logic [NLANE-1:0][NW-1:0]              mag_i,
  input  logic [NLANE-1:0]                      neg_i,
  output ctl_t                                  ctl_o,
  output logic [NLANE-1:0][OUT_FRAC_BITS+2:0]   q_o,
  output logic [NLANE-1:0]                      neg_o
);

  localparam int QW = OUT_FRAC_BITS + 3;
  localparam int NS = OUT_FRAC_BITS + 2;

  ctl_t             ctl_r [NS];
  logic [NW-1:0]    den_r [NS];
  logic [NLANE-1:0] neg_r [NS];
  logic [NW-1:0]    r_r   [NS][NLANE];
  logic [QW-1:0]    q_r   [NS][NLANE];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    ctl_t             ctl_in;
    logic [NW-1:0]    den_in;
    logic [NLANE-1:0] neg_in;
    logic [NW-1:0]    r_nxt [NLANE];
    logic [QW-1:0]    q_nxt [NLANE];

    if (s == 0) begin : g_head
      assign ctl_in = ctl_i;
      assign den_in = den_i;
      assign neg_in = neg_i;
      for (genvar k = 0; k < NLANE; k++) begin : g_lane
        logic [NW:0] m2, d2, diff2;
        logic        ge2, ge1;
        always_comb begin
          m2    = {1'b0, mag_i[k]};
          d2    = {den_i, 1'b0};
          diff2 = m2 - d2;
          ge2   = (m2 >= d2);
          ge1   = (mag_i[k] >= den_i);
          if (ge2) begin
            r_nxt[k] = diff2[NW-1:0];
            q_nxt[k] = QW'(2);
          end else if (ge1) begin
            r_nxt[k] = mag_i[k] - den_i;
            q_nxt[k] = QW'(1);
          end else begin
            r_nxt[k] = mag_i[k];
            q_nxt[k] = '0;
          end
        end
      end
    end else begin : g_body
      assign ctl_in = ctl_r[s-1];
      assign den_in = den_r[s-1];
      assign neg_in = neg_r[s-1];
      for (genvar k = 0; k < NLANE; k++) begin : g_lane
        logic [NW:0] t, dx, ts;
        logic        ge;
        always_comb begin
          t  = {r_r[s-1][k], 1'b0};
          dx = {1'b0, den_r[s-1]};
          ts = t - dx;
          ge = (t >= dx);
          r_nxt[k] = ge ? ts[NW-1:0] : t[NW-1:0];
          q_nxt[k] = {q_r[s-1][k][QW-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s] <= '0;
      end else if (en) begin
        ctl_r[s] <= ctl_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[s] <= den_in;
        neg_r[s] <= neg_in;
        for (int k = 0; k < NLANE; k++) begin
          r_r[s][k] <= r_nxt[k];
          q_r[s][k] <= q_nxt[k];
        end
      end
    end
  end

  assign ctl_o = ctl_r[NS-1];
  assign neg_o = neg_r[NS-1];
  for (genvar k = 0; k < NLANE; k++) begin : g_out
    assign q_o[k] = q_r[NS-1][k];
  end

  for (genvar k = 0; k < NLANE; k++) begin : g_chk
    a_head_rem: assert property (@(posedge clk) disable iff (!rst_n)
      (ctl_r[0].vld && !ctl_r[0].zero) |-> (r_r[0][k] < den_r[0]))
      else $error("head remainder not below norm");
    a_tail_rem: assert property (@(posedge clk) disable iff (!rst_n)
      (ctl_r[NS-1].vld && !ctl_r[NS-1].zero) |-> (r_r[NS-1][k] < den_r[NS-1]))
      else $error("final remainder not below norm");
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
      (ctl_r[NS-1].vld && !ctl_r[NS-1].zero)
        |-> (q_r[NS-1][k] <= (QW'(1) << (QW - 1))))
      else $error("quotient above two");
  end

endmodule

### sv/qrm_out.sv
module qrm_out import qrm_pkg::*; #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  ctl_t                                  ctl_i,
  input  logic [NLANE-1:0][OUT_FRAC_BITS+2:0]   q_i,
  input  logic [NLANE-1:0]                      neg_i,
  output logic                                  vld_o,
  output logic [NLANE-1:0][15:0]                e_o
);

  localparam int QW = OUT_FRAC_BITS + 3;
  localparam int EW = (OUT_FRAC_BITS + 4 > 17) ? OUT_FRAC_BITS + 4 : 17;
  localparam logic signed [EW-1:0] SMAX = EW'(32767);
  localparam logic signed [EW-1:0] SMIN = -EW'(32768);
  localparam logic signed [EW-1:0] ONE  = EW'(1) << OUT_FRAC_BITS;

  logic                      vld_r;
  logic [NLANE-1:0][15:0]    e_r, e_nxt;

  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      logic [QW:0]            inc;
      logic signed [EW-1:0]   rq;
      logic signed [EW-1:0]   v;
      inc = {1'b0, q_i[k]} + (QW+1)'(1);
      rq  = ctl_i.zero ? '0 : EW'(inc[QW:1]);
      if (is_diag(k)) begin
        v = ONE - rq;
      end else begin
        v = neg_i[k] ? -rq : rq;
      end
      if (v > SMAX) begin
        v = SMAX;
      end else if (v < SMIN) begin
        v = SMIN;
      end
      e_nxt[k] = v[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r <= e_nxt;
    end
  end

  assign vld_o = vld_r;
  assign e_o   = e_r;

endmodule

### sv/quaternion_to_rotation_matrix.sv
// Quaternion to rotation matrix. Takes one Q1.15 quaternion word per cycle and returns the
// nine entries of the normalized rotation matrix (rows forward, left, up) in signed
// Q(16-OUT_FRAC_BITS).OUT_FRAC_BITS, each ratio 2P/norm rounded once, ties away from zero,
// then saturated; a zero quaternion gives the identity. Throughput is one word per cycle
// while in_stall is low. The restoring divider's head stage gives the integer part, then
// one bit per stage for all nine entries; a stall on valid output holds the whole pipe.
module quaternion_to_rotation_matrix import qrm_pkg::*; #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [15:0] in_quat_w,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_fwd_i,
  output logic signed [15:0] out_fwd_j,
  output logic signed [15:0] out_fwd_k,
  output logic signed [15:0] out_lft_i,
  output logic signed [15:0] out_lft_j,
  output logic signed [15:0] out_lft_k,
  output logic signed [15:0] out_upr_i,
  output logic signed [15:0] out_upr_j,
  output logic signed [15:0] out_upr_k
);

  logic                                 en;
  ctl_t                                 f_ctl, d_ctl;
  logic [NW-1:0]                        f_den;
  logic [NLANE-1:0][NW-1:0]             f_mag;
  logic [NLANE-1:0]                     f_neg, d_neg;
  logic [NLANE-1:0][OUT_FRAC_BITS+2:0]  d_q;
  logic [NLANE-1:0][15:0]               e;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  qrm_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (in_valid),
    .x_i   (in_quat_x),
    .y_i   (in_quat_y),
    .z_i   (in_quat_z),
    .w_i   (in_quat_w),
    .ctl_o (f_ctl),
    .den_o (f_den),
    .mag_o (f_mag),
    .neg_o (f_neg)
  );

  qrm_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (f_ctl),
    .den_i (f_den),
    .mag_i (f_mag),
    .neg_i (f_neg),
    .ctl_o (d_ctl),
    .q_o   (d_q),
    .neg_o (d_neg)
  );

  qrm_out #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_out (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (d_ctl),
    .q_i   (d_q),
    .neg_i (d_neg),
    .vld_o (out_valid),
    .e_o   (e)
  );

  assign out_fwd_i = e[0];
  assign out_fwd_j = e[1];
  assign out_fwd_k = e[2];
  assign out_lft_i = e[3];
  assign out_lft_j = e[4];
  assign out_lft_k = e[5];
  assign out_upr_i = e[6];
  assign out_upr_j = e[7];
  assign out_upr_k = e[8];

endmodule
